// ===== rtl/core/bqd_pkg.sv =====
`default_nettype none

package bqd_pkg;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctrl;

    // Register map, by word index.
    localparam logic [2:0] REG_B0   = 3'd0;
    localparam logic [2:0] REG_B1   = 3'd1;
    localparam logic [2:0] REG_B2   = 3'd2;
    localparam logic [2:0] REG_FB1  = 3'd3;
    localparam logic [2:0] REG_FB2  = 3'd4;
    localparam logic [2:0] REG_NORM = 3'd5;

    // Product terms, in the order the sequencer issues them.
    localparam logic [2:0] TAP_B0  = 3'd0;
    localparam logic [2:0] TAP_B1  = 3'd1;
    localparam logic [2:0] TAP_B2  = 3'd2;
    localparam logic [2:0] TAP_FB1 = 3'd3;
    localparam logic [2:0] TAP_FB2 = 3'd4;

    // Reset value of b0 and a0: 64.0 in Q16.16.
    localparam logic [63:0] COEF_RST_UNITY = 64'd4194304;

endpackage

`default_nettype wire

// ===== rtl/core/bqd_mac.sv =====
`default_nettype none

module bqd_mac #(
    parameter int COEF_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 24,
    parameter int ACC_WIDTH    = 59
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bqd_pkg::t_mac_ctrl      i_ctrl,
    input  wire signed [COEF_WIDTH-1:0]  i_coef,
    input  wire signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [ACC_WIDTH-1:0]  o_acc
);

    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;

    logic signed [PROD_WIDTH-1:0] r_prod;
    logic                         r_prod_vld;
    logic signed [ACC_WIDTH-1:0]  r_acc;

    // The product is registered before it reaches the adder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_WIDTH'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== rtl/core/bqd_div.sv =====
`default_nettype none

module bqd_div #(
    parameter int DIVIDEND_WIDTH = 58,
    parameter int DIVISOR_WIDTH  = 31
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [DIVIDEND_WIDTH-1:0]  i_dividend,
    input  wire [DIVISOR_WIDTH-1:0]   i_divisor,
    output logic [DIVIDEND_WIDTH-1:0] o_quotient,
    output logic                      o_done
);

    localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DIVIDEND_WIDTH - 1);

    logic [DIVIDEND_WIDTH-1:0] r_work;
    logic [DIVISOR_WIDTH-1:0]  r_rem;
    logic [CNT_WIDTH-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [DIVISOR_WIDTH:0]    shifted;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      ge;
    logic [DIVISOR_WIDTH-1:0]  n_rem;

    // Restoring division, one quotient bit per cycle. Quotient bits shift
    // into the low end of the dividend register as dividend bits leave it.
    always_comb begin
        shifted = {r_rem, r_work[DIVIDEND_WIDTH-1]};
        diff    = shifted - {1'b0, i_divisor};
        ge      = (shifted >= {1'b0, i_divisor});
        n_rem   = ge ? diff[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= {r_work[DIVIDEND_WIDTH-2:0], ge};
            r_rem  <= n_rem;
        end
    end

    assign o_quotient = r_work;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/biquad_iir_filter.sv =====
// Requests are taken one at a time: a new request is accepted only once the previous result
// is committed, since each one makes five passes through the shared multiplier and then goes
// through the bit-serial divider that follows them.
// Reset (synchronous, active low) clears the sample history, loads b0 = a0 = 64.0 and the
// other coefficients with zero, and empties the result register.
`default_nettype none

module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    // Configuration port
    input  wire                                         psel,
    input  wire                                         penable,
    input  wire                                         pwrite,
    input  wire [((COEF_WIDTH > 32) ? 6 : 5)-1:0]       paddr,
    input  wire [((COEF_WIDTH > 32) ? 64 : 32)-1:0]     pwdata,
    output logic [((COEF_WIDTH > 32) ? 64 : 32)-1:0]    prdata,
    output logic                                        pready,
    // Sample request channel
    input  wire                                         i_in_valid,
    output logic                                        o_in_ready,
    input  wire signed [SAMPLE_WIDTH-1:0]               i_sample_in,
    // Result channel
    output logic                                        o_out_valid,
    input  wire                                         i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]              o_sample_out,
    output logic                                        o_clipped
);

    localparam int DATA_WIDTH = (COEF_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_WIDTH = (COEF_WIDTH > 32) ? 6 : 5;
    // Five products of COEF_WIDTH + SAMPLE_WIDTH bits need three guard bits.
    localparam int ACC_WIDTH  = COEF_WIDTH + SAMPLE_WIDTH + 3;
    localparam int MAG_WIDTH  = ACC_WIDTH - 1;
    localparam int NORM_WIDTH = COEF_WIDTH - 1;

    localparam logic [SAMPLE_WIDTH-1:0] SAMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // ------------------------------------------------------------------
    // Coefficient registers. Writes land on the access phase; an index
    // past the normalizing divisor is ignored and reads back as zero.
    // ------------------------------------------------------------------
    logic [COEF_WIDTH-1:0] r_b0, r_b1, r_b2, r_fb1, r_fb2;
    logic [NORM_WIDTH-1:0] r_norm;
    logic [2:0]            reg_idx;
    logic                  cfg_wr;

    assign reg_idx = paddr[ADDR_WIDTH-1:ADDR_WIDTH-3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0   <= COEF_WIDTH'(bqd_pkg::COEF_RST_UNITY);
            r_b1   <= '0;
            r_b2   <= '0;
            r_fb1  <= '0;
            r_fb2  <= '0;
            r_norm <= NORM_WIDTH'(bqd_pkg::COEF_RST_UNITY);
        end else if (cfg_wr) begin
            case (reg_idx)
                bqd_pkg::REG_B0:   r_b0   <= pwdata[COEF_WIDTH-1:0];
                bqd_pkg::REG_B1:   r_b1   <= pwdata[COEF_WIDTH-1:0];
                bqd_pkg::REG_B2:   r_b2   <= pwdata[COEF_WIDTH-1:0];
                bqd_pkg::REG_FB1:  r_fb1  <= pwdata[COEF_WIDTH-1:0];
                bqd_pkg::REG_FB2:  r_fb2  <= pwdata[COEF_WIDTH-1:0];
                bqd_pkg::REG_NORM: r_norm <= pwdata[NORM_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bqd_pkg::REG_B0:   prdata = DATA_WIDTH'(r_b0);
            bqd_pkg::REG_B1:   prdata = DATA_WIDTH'(r_b1);
            bqd_pkg::REG_B2:   prdata = DATA_WIDTH'(r_b2);
            bqd_pkg::REG_FB1:  prdata = DATA_WIDTH'(r_fb1);
            bqd_pkg::REG_FB2:  prdata = DATA_WIDTH'(r_fb2);
            bqd_pkg::REG_NORM: prdata = DATA_WIDTH'(r_norm);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. A request is latched, then the five products are issued
    // one per cycle to the shared multiplier, the accumulator is turned
    // into sign and magnitude, and the magnitude is divided by a0 one bit
    // per cycle. The quotient is saturated and handed to the result
    // register; the history moves only when the result is committed.
    // ------------------------------------------------------------------
    logic [2:0]                    r_state;
    logic [2:0]                    r_k;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_xh1, r_xh2, r_yh1, r_yh2;
    logic                          r_neg;
    logic                          r_zero;
    logic                          r_out_valid;
    logic [SAMPLE_WIDTH-1:0]       r_out_sample;
    logic                          r_out_clip;

    bqd_pkg::t_mac_ctrl            mac_ctrl;
    logic signed [COEF_WIDTH-1:0]   mac_coef;
    logic signed [SAMPLE_WIDTH-1:0] mac_sample;
    logic signed [ACC_WIDTH-1:0]    acc;
    logic [ACC_WIDTH-1:0]           acc_mag;
    logic                           div_start;
    logic [MAG_WIDTH-1:0]           quot;
    logic                           div_done;

    logic                    commit;
    logic                    over;
    logic [SAMPLE_WIDTH-1:0] lim;
    logic [SAMPLE_WIDTH-1:0] q_sat;
    logic [SAMPLE_WIDTH-1:0] res;

    assign o_in_ready = (r_state == ST_IDLE);

    // Operand selection for the current product term.
    always_comb begin
        case (r_k)
            bqd_pkg::TAP_B0: begin
                mac_coef   = r_b0;
                mac_sample = r_x;
            end
            bqd_pkg::TAP_B1: begin
                mac_coef   = r_b1;
                mac_sample = r_xh1;
            end
            bqd_pkg::TAP_B2: begin
                mac_coef   = r_b2;
                mac_sample = r_xh2;
            end
            bqd_pkg::TAP_FB1: begin
                mac_coef   = r_fb1;
                mac_sample = r_yh1;
            end
            default: begin
                mac_coef   = r_fb2;
                mac_sample = r_yh2;
            end
        endcase
        mac_ctrl.en  = (r_state == ST_MAC);
        mac_ctrl.clr = (r_state == ST_MAC) && (r_k == bqd_pkg::TAP_B0);
    end

    bqd_mac #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_coef   (mac_coef),
        .i_sample (mac_sample),
        .o_acc    (acc)
    );

    // The accumulator never reaches the most negative value, so its
    // magnitude fits one bit narrower.
    assign acc_mag   = acc[ACC_WIDTH-1] ? (~acc + 1'b1) : acc;
    assign div_start = (r_state == ST_MAG);

    bqd_div #(
        .DIVIDEND_WIDTH (MAG_WIDTH),
        .DIVISOR_WIDTH  (NORM_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_mag[MAG_WIDTH-1:0]),
        .i_divisor  (r_norm),
        .o_quotient (quot),
        .o_done     (div_done)
    );

    // Saturation. A zero divisor yields an all-ones quotient, which clips
    // to the range end of the accumulator's sign; a zero accumulator
    // always gives zero and is never reported as clipped.
    always_comb begin
        lim   = r_neg ? SAMP_MIN : SAMP_MAX;
        over  = (quot > MAG_WIDTH'(lim));
        q_sat = over ? lim : quot[SAMPLE_WIDTH-1:0];
        if (r_zero) begin
            res = '0;
        end else if (r_neg) begin
            res = ~q_sat + 1'b1;
        end else begin
            res = q_sat;
        end
    end

    assign commit = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= bqd_pkg::TAP_B0;
            r_out_valid <= 1'b0;
            r_xh1       <= '0;
            r_xh2       <= '0;
            r_yh1       <= '0;
            r_yh2       <= '0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_MAC;
                        r_k     <= bqd_pkg::TAP_B0;
                    end
                end
                ST_MAC: begin
                    if (r_k == bqd_pkg::TAP_FB2) begin
                        r_state <= ST_ACC;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_ACC: begin
                    r_state <= ST_MAG;
                end
                ST_MAG: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (commit) begin
                        r_state <= ST_IDLE;
                        r_xh2   <= r_xh1;
                        r_xh1   <= r_x;
                        r_yh2   <= r_yh1;
                        r_yh1   <= res;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_x <= i_sample_in;
        end
        if (div_start) begin
            r_neg  <= acc[ACC_WIDTH-1];
            r_zero <= (acc == '0);
        end
        if (commit) begin
            r_out_sample <= res;
            r_out_clip   <= over && !r_zero;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while a sample is still in progress");

    a_clip_at_range_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |-> (o_sample_out == SAMP_MAX || o_sample_out == SAMP_MIN))
        else $error("clipped result is not at a range end");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k <= bqd_pkg::TAP_FB2))
        else $error("product term index out of range");

    a_commit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && $past(r_state) == ST_DIV) |-> $past(div_done))
        else $error("result stage entered without a finished division");

endmodule

`default_nettype wire

// ===== test/biquad_iir_filter_tb.sv =====
`default_nettype none

module biquad_iir_filter_tb;

    localparam int SW = 24;
    localparam int CW = 32;

    // Register indexes past the end of the map. Writes to them must change nothing.
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    localparam logic signed [SW-1:0] SMP_MAX = 24'sh7F_FFFF;
    localparam logic signed [SW-1:0] SMP_MIN = 24'sh80_0000;

    localparam logic [31:0] COEF_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q16_ONE   = 32'h0001_0000;

    // Quiet tail waited out after the last result is checked, before the run ends.
    localparam int TAIL_CYCLES  = 80;
    // The long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES  = 400;
    // Longest correct quiet stretch is the hold-off plus one pass through the block.
    localparam int STALL_LIMIT  = 4000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 116;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    // One line of the directed table: a register write or a sample request. Where the
    // answer is obvious it is typed in, otherwise the filter model supplies it.
    typedef struct {
        t_row_kind           kind;
        logic [2:0]          idx;
        logic [31:0]         data;
        logic signed [SW-1:0] smp;
        bit                  known;
        logic signed [SW-1:0] want_smp;
        bit                  want_clip;
    } t_stim_row;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 clip;
    } t_filt_out;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [4:0]           paddr        = '0;
    logic [31:0]          pwdata       = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic signed [SW-1:0] i_sample_in  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic signed [SW-1:0] o_sample_out;
    logic                 o_clipped;

    biquad_iir_filter #(
        .SAMPLE_WIDTH (SW),
        .COEF_WIDTH   (CW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    always #4 i_clk = ~i_clk;

    // Filter model state: our own copy of the coefficients and of the sample history.
    logic signed [CW-1:0] k_b0   = bqd_pkg::COEF_RST_UNITY[CW-1:0];
    logic signed [CW-1:0] k_b1   = '0;
    logic signed [CW-1:0] k_b2   = '0;
    logic signed [CW-1:0] k_fb1  = '0;
    logic signed [CW-1:0] k_fb2  = '0;
    logic [CW-2:0]        k_norm = bqd_pkg::COEF_RST_UNITY[CW-2:0];
    logic signed [SW-1:0] x_d1   = '0;
    logic signed [SW-1:0] x_d2   = '0;
    logic signed [SW-1:0] y_d1   = '0;
    logic signed [SW-1:0] y_d2   = '0;

    // Filtered samples still owed by the block, oldest first.
    t_filt_out filtered_q[$];

    int err_cnt       = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // The stimulus side bumps hold_tickets to ask for a hold-off; the receiver counts it down.
    int hold_tickets  = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    t_filt_out head;

    t_stim_row dir_rows[$];

    function automatic logic signed [79:0] tap(logic signed [CW-1:0] c, logic signed [SW-1:0] s);
        logic signed [79:0] ce;
        logic signed [79:0] se;
        ce = c;
        se = s;
        return ce * se;
    endfunction

    // One step of the direct form I section. The sum is kept exact at 80 bits, which is far
    // more than five 32x24 products can need, then divided by a0 with truncation toward zero
    // and saturated. The saturated value goes back into the output history.
    function automatic t_filt_out advance_filter(logic signed [SW-1:0] x);
        logic signed [79:0] acc;
        logic [79:0]        mag;
        logic [79:0]        quot;
        logic [79:0]        lim;
        logic               neg;
        t_filt_out          r;
        acc = tap(k_b0, x) + tap(k_b1, x_d1) + tap(k_b2, x_d2) + tap(k_fb1, y_d1)
            + tap(k_fb2, y_d2);
        neg = acc[79];
        mag = neg ? -acc : acc;
        lim = neg ? 80'd8388608 : 80'd8388607;
        if (k_norm == '0) begin
            // A zero divisor sends any nonzero sum to the rail of its own sign.
            r.clip = (mag != '0);
            quot = r.clip ? lim : '0;
        end else begin
            quot = mag / {49'd0, k_norm};
            r.clip = (quot > lim);
            if (r.clip) begin
                quot = lim;
            end
        end
        r.smp = neg ? SW'(-quot) : SW'(quot);
        x_d2 = x_d1;
        x_d1 = x;
        y_d2 = y_d1;
        y_d1 = r.smp;
        return r;
    endfunction

    function automatic t_stim_row row_wr(logic [2:0] idx, logic [31:0] data);
        t_stim_row r;
        r = '{ROW_WRITE, idx, data, '0, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic t_stim_row row_smp(logic signed [SW-1:0] x);
        t_stim_row r;
        r = '{ROW_SAMPLE, bqd_pkg::REG_B0, '0, x, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic t_stim_row row_known(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                                            bit c);
        t_stim_row r;
        r = '{ROW_SAMPLE, bqd_pkg::REG_B0, '0, x, 1'b1, y, c};
        return r;
    endfunction

    // Mostly full-range patterns so every input bit toggles, plus quiet signals and rails.
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return '0;
                    3: return 24'sd1;
                    default: return -24'sd1;
                endcase
            end
            1, 2: return SW'(int'($urandom_range(2000)) - 1000);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_rail_coef();
        case ($urandom_range(3))
            0: return COEF_MIN;
            1: return COEF_MAX;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Setup cycle then access cycle. The bus is left selected so that back-to-back writes
    // do not need psel dropped and raised in the same step; bus_release ends a burst.
    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            bqd_pkg::REG_B0:   k_b0   = data;
            bqd_pkg::REG_B1:   k_b1   = data;
            bqd_pkg::REG_B2:   k_b2   = data;
            bqd_pkg::REG_FB1:  k_fb1  = data;
            bqd_pkg::REG_FB2:  k_fb2  = data;
            bqd_pkg::REG_NORM: k_norm = data[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (filtered_q.size() != 0) @(posedge i_clk);
    endtask

    // Offer one sample and hold it until taken. Afterwards the sender may drop valid and idle
    // at random; if it does not, valid stays high and the caller either offers the next sample
    // in the same step or lowers valid itself.
    task automatic offer_sample(logic signed [SW-1:0] x, bit known, logic signed [SW-1:0] y,
                                bit c);
        t_filt_out p;
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        p = advance_filter(x);
        if (known) begin
            p.smp  = y;
            p.clip = c;
        end
        filtered_q.push_back(p);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Loads a fresh coefficient set. Style 0 is a plausible filter scaled to a0, style 1 is
    // raw random bits, style 2 sits on the rails with a0 at its smallest or largest.
    task automatic load_coefs(int style, int phase);
        logic [31:0] norm;
        logic [31:0] c[5];
        int          span;
        case (style)
            0: begin
                norm = Q16_ONE * $urandom_range(64, 1);
                span = 2 * int'(norm);
                foreach (c[i]) c[i] = 32'(int'($urandom_range(2 * span)) - span);
            end
            1: begin
                norm = $urandom_range(32'h7FFF_FFFF, 1);
                foreach (c[i]) c[i] = $urandom;
            end
            default: begin
                norm = (phase < 4) ? 32'd1 : 32'h7FFF_FFFF;
                foreach (c[i]) c[i] = pick_rail_coef();
            end
        endcase
        apb_write(bqd_pkg::REG_B0,  c[0]);
        apb_write(bqd_pkg::REG_B1,  c[1]);
        apb_write(bqd_pkg::REG_B2,  c[2]);
        apb_write(bqd_pkg::REG_FB1, c[3]);
        apb_write(bqd_pkg::REG_FB2, c[4]);
        apb_write(bqd_pkg::REG_NORM, norm);
        bus_release();
    endtask

    // Result side: checks every accepted result against the oldest expectation and drives
    // ready, randomly or held low for a long stretch when asked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_q.size() == 0) begin
                $error("unexpected result: sample_out %0d clipped %0b", o_sample_out, o_clipped);
                err_cnt++;
            end else begin
                head = filtered_q.pop_front();
                if (o_sample_out !== head.smp) begin
                    $error("sample_out: expected %0d, got %0d", head.smp, o_sample_out);
                    err_cnt++;
                end
                if (o_clipped !== head.clip) begin
                    $error("clipped: expected %0b, got %0b", head.clip, o_clipped);
                    err_cnt++;
                end
            end
        end
        if (hold_done != hold_tickets) begin
            hold_done = hold_tickets;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any accepted request, result or register write restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $error("no handshake for %0d cycles, %0d results outstanding", STALL_LIMIT,
               filtered_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // Directed part. After reset b0 = a0 = 64.0, so the section passes samples through.
        // Then a zero divisor, a0 with its unused top bit set, full-scale b0 driving both
        // rails, truncation toward zero on odd quotients, writes past the register map, and
        // finally b0 on its negative rail with the other taps set, under the largest and smallest a0.
        dir_rows = '{
            row_known(SMP_MAX, SMP_MAX, 1'b0),
            row_known(SMP_MIN, SMP_MIN, 1'b0),
            row_known(24'sd0, 24'sd0, 1'b0),
            row_known(24'sd1, 24'sd1, 1'b0),
            row_known(-24'sd1, -24'sd1, 1'b0),
            row_known(24'sh55_5555, 24'sh55_5555, 1'b0),
            row_known(24'shAA_AAAA, 24'shAA_AAAA, 1'b0),
            row_wr(bqd_pkg::REG_NORM, 32'd0),
            row_wr(bqd_pkg::REG_B0, Q16_ONE),
            row_known(24'sd5, SMP_MAX, 1'b1),
            row_known(-24'sd5, SMP_MIN, 1'b1),
            row_known(24'sd0, 24'sd0, 1'b0),
            row_wr(bqd_pkg::REG_NORM, 32'h8001_0000),
            row_wr(bqd_pkg::REG_B0, COEF_MAX),
            row_known(SMP_MAX, SMP_MAX, 1'b1),
            row_known(SMP_MIN, SMP_MIN, 1'b1),
            row_wr(bqd_pkg::REG_B0, Q16_ONE),
            row_wr(bqd_pkg::REG_NORM, 32'h0003_0000),
            row_known(24'sd7, 24'sd2, 1'b0),
            row_known(-24'sd7, -24'sd2, 1'b0),
            row_wr(REG_SPARE6, 32'hFFFF_FFFF),
            row_wr(REG_SPARE7, 32'hFFFF_FFFF),
            row_known(24'sd9, 24'sd3, 1'b0),
            row_wr(bqd_pkg::REG_B0, COEF_MIN),
            row_wr(bqd_pkg::REG_B1, 32'h0001_8000),
            row_wr(bqd_pkg::REG_B2, 32'hFFFF_4000),
            row_wr(bqd_pkg::REG_FB1, 32'h0001_C000),
            row_wr(bqd_pkg::REG_FB2, 32'hFFFF_3000),
            row_wr(bqd_pkg::REG_NORM, COEF_MAX),
            row_smp(24'sd1000),
            row_smp(-24'sd123456),
            row_smp(SMP_MAX),
            row_smp(SMP_MIN),
            row_smp(24'sd0),
            row_smp(24'sd42),
            row_wr(bqd_pkg::REG_NORM, 32'd1),
            row_smp(24'sd3),
            row_smp(-24'sd3)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                wait_drained();
                apb_write(dir_rows[r].idx, dir_rows[r].data);
                if (r == dir_rows.size() - 1 || dir_rows[r + 1].kind != ROW_WRITE) begin
                    bus_release();
                end
            end else begin
                offer_sample(dir_rows[r].smp, dir_rows[r].known, dir_rows[r].want_smp,
                             dir_rows[r].want_clip);
                if (r == dir_rows.size() - 1 || dir_rows[r + 1].kind != ROW_SAMPLE) begin
                    i_in_valid <= 1'b0;
                end
            end
        end

        // Random part: each phase waits for the block to go idle, loads new coefficients
        // and streams samples under one of four idling patterns. Phase 4 also holds the
        // result side off long enough that the block has to refuse new requests.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            load_coefs(p % 3, p);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 78;
                end
                default: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 15;
                end
            endcase
            if (p == 4) begin
                hold_tickets++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer_sample(pick_sample(), 1'b0, '0, 1'b0);
            end
            i_in_valid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
